FILE: hdl/etbpd_pkg.sv
// etbpd_pkg: shared constants, register indexes and types for the
// error tolerant bit pattern detector
// no dependencies
package etbpd_pkg;

   // history bits held by one cell
   localparam int CELL_BITS = 8;
   // width of one cell's mismatch count
   localparam int CNT_W = $clog2(CELL_BITS + 1);
   // cells summed by one group adder
   localparam int GRP_CELLS = 4;
   // width of one group sum
   localparam int GRP_W = $clog2(GRP_CELLS * CELL_BITS + 1);
   // largest supported history length
   localparam int MAX_BITS = 128;
   // width of the total error count
   localparam int SUM_W = 8;
   // half of the pattern or mask
   localparam int HALF_W = 64;
   // csr port widths
   localparam int CSR_DATA_W = 64;
   localparam int CSR_IDX_W = 3;
   localparam int MAXERR_W = 8;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_PAT_RECENT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PAT_OLDER  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MSK_RECENT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MSK_OLDER  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_ERR    = 3'd4;

   // stage advance strobes from the pipeline control to the adder tree
   typedef struct packed {
      logic load_grp;
      logic load_out;
   } adv_type;

endpackage

FILE: hdl/etbpd_cell.sv
// etbpd_cell: one slice of the history shift chain with its own
// masked mismatch count; uses etbpd_pkg
module etbpd_cell #(
   parameter int FIRST_POS = 0,
   parameter int REG_BITS  = 128
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              shift_en,
   input  logic                              carry_in,
   output logic                              carry_out,
   input  logic [etbpd_pkg::CELL_BITS-1:0]   pattern,
   input  logic [etbpd_pkg::CELL_BITS-1:0]   mask,
   output logic [etbpd_pkg::CNT_W-1:0]       count
);

   localparam int W = etbpd_pkg::CELL_BITS;

   logic [W-1:0]                  history_ff;
   logic [W-1:0]                  history_in;
   logic [W-1:0]                  lane_ok;
   logic [W-1:0]                  diff;
   logic [etbpd_pkg::CNT_W-1:0]   count_ff;
   logic [etbpd_pkg::CNT_W-1:0]   count_in;

   // positions at or beyond the history length never count
   genvar gi;
   generate
      for (gi = 0; gi < W; gi++) begin : g_lane
         assign lane_ok[gi] = (FIRST_POS + gi < REG_BITS);
      end
   endgenerate

   // shift by one, lowest bit from the younger neighbor
   assign history_in = {history_ff[W-2:0], carry_in};
   assign carry_out  = history_ff[W-1];

   // mismatch of the shifted history against the pattern
   assign diff = (history_in ^ pattern) & mask & lane_ok;

   always_comb begin
      count_in = '0;
      for (int i = 0; i < W; i++) begin
         count_in = count_in + etbpd_pkg::CNT_W'(diff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         history_ff <= '0;
      end else if (shift_en) begin
         history_ff <= history_in;
      end
   end

   // count register is the first pipeline stage
   always_ff @(posedge clock) begin
      if (shift_en) begin
         count_ff <= count_in;
      end
   end

   assign count = count_ff;

endmodule

FILE: hdl/etbpd_sum.sv
// etbpd_sum: registered group adders over the cell counts and the
// final total; uses etbpd_pkg
module etbpd_sum #(
   parameter int NUM_CELLS = 16
) (
   input  logic                              clock,
   input  etbpd_pkg::adv_type                adv,
   input  logic [etbpd_pkg::CNT_W-1:0]       counts [NUM_CELLS],
   output logic [etbpd_pkg::SUM_W-1:0]       total
);

   localparam int NUM_GROUPS = (NUM_CELLS + etbpd_pkg::GRP_CELLS - 1) / etbpd_pkg::GRP_CELLS;

   logic [etbpd_pkg::GRP_W-1:0] group_ff [NUM_GROUPS];
   logic [etbpd_pkg::GRP_W-1:0] group_in [NUM_GROUPS];

   // sum up to four cell counts per group
   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         group_in[g] = '0;
         for (int j = 0; j < etbpd_pkg::GRP_CELLS; j++) begin
            if (g * etbpd_pkg::GRP_CELLS + j < NUM_CELLS) begin
               group_in[g] = group_in[g]
                  + etbpd_pkg::GRP_W'(counts[g * etbpd_pkg::GRP_CELLS + j]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv.load_grp) begin
         for (int g = 0; g < NUM_GROUPS; g++) begin
            group_ff[g] <= group_in[g];
         end
      end
   end

   // final total over the group sums
   always_comb begin
      total = '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         total = total + etbpd_pkg::SUM_W'(group_ff[g]);
      end
   end

endmodule

FILE: hdl/error_tolerant_bit_pattern_detector_core.sv
// error_tolerant_bit_pattern_detector_core: top level of the sync word
// correlator; uses etbpd_pkg, etbpd_cell and etbpd_sum
//
// channel   direction  contents
// req_*     in         tdata[0] in_bit, one received bit per request
// rsp_*     out        tdata[7:0] error_count, tdata[8] match
// csr_*     in         write enable, register index, 64-bit write data
//
// one request per cycle while req_tready is high; the result passes the
// per-cell count stage, the group adder stage and the final add and
// compare in the output register before rsp_tvalid rises
// reset clears the history, the configuration registers and the stage valid flags
// a stalled output lets the pipeline fill; req_tready drops only when all
// three stages hold a request
module error_tolerant_bit_pattern_detector_core #(
   parameter int REG_BITS = 128
) (
   input  logic          clock,
   input  logic          reset,
   // request channel
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [7:0]    req_tdata,    // [0] in_bit, [7:1] zero
   // result channel
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [15:0]   rsp_tdata,    // [7:0] error_count, [8] match, [15:9] zero
   // register write port
   input  logic                                csr_we,
   input  logic [etbpd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [etbpd_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int W         = etbpd_pkg::CELL_BITS;
   localparam int NUM_CELLS = (REG_BITS + W - 1) / W;

   // configuration registers
   logic [etbpd_pkg::HALF_W-1:0]   pat_recent_ff;
   logic [etbpd_pkg::HALF_W-1:0]   pat_older_ff;
   logic [etbpd_pkg::HALF_W-1:0]   msk_recent_ff;
   logic [etbpd_pkg::HALF_W-1:0]   msk_older_ff;
   logic [etbpd_pkg::MAXERR_W-1:0] max_err_ff;

   logic [etbpd_pkg::MAX_BITS-1:0] pattern_all;
   logic [etbpd_pkg::MAX_BITS-1:0] mask_all;

   // pipeline control
   logic                 cell_vld_ff;
   logic                 grp_vld_ff;
   logic                 out_vld_ff;
   logic                 accept;
   logic                 grp_free;
   etbpd_pkg::adv_type   adv;

   // cell chain and results
   logic                              carry [NUM_CELLS+1];
   logic [etbpd_pkg::CNT_W-1:0]       counts [NUM_CELLS];
   logic [etbpd_pkg::SUM_W-1:0]       total;
   logic [etbpd_pkg::SUM_W-1:0]       count_ff;
   logic                              match_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         pat_recent_ff <= '0;
         pat_older_ff  <= '0;
         msk_recent_ff <= '0;
         msk_older_ff  <= '0;
         max_err_ff    <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            etbpd_pkg::REG_PAT_RECENT: pat_recent_ff <= csr_wdata;
            etbpd_pkg::REG_PAT_OLDER:  pat_older_ff  <= csr_wdata;
            etbpd_pkg::REG_MSK_RECENT: msk_recent_ff <= csr_wdata;
            etbpd_pkg::REG_MSK_OLDER:  msk_older_ff  <= csr_wdata;
            etbpd_pkg::REG_MAX_ERR:    max_err_ff    <= csr_wdata[etbpd_pkg::MAXERR_W-1:0];
            default: ;
         endcase
      end
   end

   assign pattern_all = {pat_older_ff, pat_recent_ff};
   assign mask_all    = {msk_older_ff, msk_recent_ff};

   // stage advance, each stage moves when the next one is free or moving
   assign adv.load_out = grp_vld_ff && (!out_vld_ff || rsp_tready);
   assign grp_free     = !grp_vld_ff || adv.load_out;
   assign adv.load_grp = cell_vld_ff && grp_free;
   assign req_tready   = !cell_vld_ff || adv.load_grp;
   assign accept       = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_vld_ff <= 1'b0;
         grp_vld_ff  <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         if (accept) begin
            cell_vld_ff <= 1'b1;
         end else if (adv.load_grp) begin
            cell_vld_ff <= 1'b0;
         end
         if (adv.load_grp) begin
            grp_vld_ff <= 1'b1;
         end else if (adv.load_out) begin
            grp_vld_ff <= 1'b0;
         end
         if (adv.load_out) begin
            out_vld_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   // chain of history cells, newest bit enters the first cell
   assign carry[0] = req_tdata[0];

   genvar gc;
   generate
      for (gc = 0; gc < NUM_CELLS; gc++) begin : g_cell
         etbpd_cell #(
            .FIRST_POS (gc * W),
            .REG_BITS  (REG_BITS)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .shift_en  (accept),
            .carry_in  (carry[gc]),
            .carry_out (carry[gc+1]),
            .pattern   (pattern_all[gc*W +: W]),
            .mask      (mask_all[gc*W +: W]),
            .count     (counts[gc])
         );
      end
   endgenerate

   // adder tree over the cell counts
   etbpd_sum #(
      .NUM_CELLS (NUM_CELLS)
   ) u_sum (
      .clock  (clock),
      .adv    (adv),
      .counts (counts),
      .total  (total)
   );

   // output register with the threshold compare
   always_ff @(posedge clock) begin
      if (adv.load_out) begin
         count_ff <= total;
         match_ff <= (total <= max_err_ff);
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {7'd0, match_ff, count_ff};

`ifndef SYNTH
   // the error count never exceeds the history length
   assert property (@(posedge clock) disable iff (reset)
      out_vld_ff |-> (count_ff <= etbpd_pkg::SUM_W'(REG_BITS)))
      else $error("error count above history length");

   // with the later stages empty a result is offered once its request has passed the count, group and output registers
   assert property (@(posedge clock) disable iff (reset)
      accept && !grp_vld_ff && !out_vld_ff |-> ##3 rsp_tvalid)
      else $error("request lost in pipeline");

   // requests are refused only when every stage is occupied
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (cell_vld_ff && grp_vld_ff && out_vld_ff))
      else $error("request refused with a free stage");
`endif

endmodule

FILE: tb/etbpd_tb_pkg.sv
`timescale 1ns / 1ps
// etbpd_tb_pkg: result record and correlation scoreboard for the bit pattern
// detector bench; depends on etbpd_pkg
package etbpd_tb_pkg;

   // indexes past the last register, writes there must change nothing
   localparam logic [etbpd_pkg::CSR_IDX_W-1:0] REG_SPARE_LO = 3'd5;
   localparam logic [etbpd_pkg::CSR_IDX_W-1:0] REG_SPARE_HI = 3'd7;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic                          match;
      logic [etbpd_pkg::SUM_W-1:0]   error_count;
   } corr_result_type;

   class correlator_scoreboard;
      bit [etbpd_pkg::MAX_BITS-1:0] pattern;
      bit [etbpd_pkg::MAX_BITS-1:0] care_mask;
      bit [etbpd_pkg::MAX_BITS-1:0] history;
      bit [etbpd_pkg::MAXERR_W-1:0] max_err;
      corr_result_type              expected_corr_q[$];
      int unsigned                  failures;
      int unsigned                  checked;

      function new();
         pattern   = '0;
         care_mask = '0;
         history   = '0;
         max_err   = '0;
         failures  = 0;
         checked   = 0;
      endfunction

      // mirror of a register write
      function void write_reg(logic [etbpd_pkg::CSR_IDX_W-1:0] index,
                              logic [etbpd_pkg::CSR_DATA_W-1:0] value);
         case (index)
            etbpd_pkg::REG_PAT_RECENT:
               pattern[etbpd_pkg::HALF_W-1:0] = value;
            etbpd_pkg::REG_PAT_OLDER:
               pattern[etbpd_pkg::MAX_BITS-1:etbpd_pkg::HALF_W] = value;
            etbpd_pkg::REG_MSK_RECENT:
               care_mask[etbpd_pkg::HALF_W-1:0] = value;
            etbpd_pkg::REG_MSK_OLDER:
               care_mask[etbpd_pkg::MAX_BITS-1:etbpd_pkg::HALF_W] = value;
            etbpd_pkg::REG_MAX_ERR:
               max_err = value[etbpd_pkg::MAXERR_W-1:0];
            default: ;
         endcase
      endfunction

      // shift in an accepted bit and queue the correlation it produces
      function void predict_correlation(bit in_bit);
         corr_result_type exp_r;
         int              n;
         history = {history[etbpd_pkg::MAX_BITS-2:0], in_bit};
         n = $countones((history ^ pattern) & care_mask);
         exp_r.error_count = n[etbpd_pkg::SUM_W-1:0];
         exp_r.match       = (exp_r.error_count <= max_err);
         expected_corr_q.push_back(exp_r);
      endfunction

      // compare one accepted result with the oldest prediction
      function void check_correlation(logic [15:0] tdata);
         corr_result_type               exp_r;
         logic [etbpd_pkg::SUM_W-1:0]   got_count;
         logic                          got_match;
         got_count = tdata[etbpd_pkg::SUM_W-1:0];
         got_match = tdata[etbpd_pkg::SUM_W];
         if (expected_corr_q.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("unexpected result: error_count %0d match %0b", got_count, got_match);
            return;
         end
         exp_r = expected_corr_q.pop_front();
         if (got_count !== exp_r.error_count || got_match !== exp_r.match) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("result %0d: error_count exp %0d got %0d, match exp %0b got %0b",
                        checked, exp_r.error_count, got_count, exp_r.match, got_match);
         end
         checked++;
      endfunction

      function int pending();
         return expected_corr_q.size();
      endfunction
   endclass

endpackage

FILE: tb/error_tolerant_bit_pattern_detector_core_tb.sv
`timescale 1ns / 1ps
// error_tolerant_bit_pattern_detector_core_tb: streams bits with random gaps and
// stalls, predicts every correlation result; uses etbpd_pkg and etbpd_tb_pkg
module error_tolerant_bit_pattern_detector_core_tb;

   localparam int ITEM_TARGET  = 1800;
   localparam int PHASE_ITEMS  = 120;
   localparam int LONG_HOLD    = 300;
   localparam int DRAIN_CYCLES = 20;

   logic                               clock      = 1'b0;
   logic                               reset      = 1'b1;
   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic [7:0]                         req_tdata  = '0;
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   logic [15:0]                        rsp_tdata;
   logic                               csr_we     = 1'b0;
   logic [etbpd_pkg::CSR_IDX_W-1:0]    csr_index  = '0;
   logic [etbpd_pkg::CSR_DATA_W-1:0]   csr_wdata  = '0;

   etbpd_tb_pkg::correlator_scoreboard sb = new();

   int bits_sent     = 0;
   bit req_gaps_on   = 1'b1;
   bit rsp_stalls_on = 1'b1;
   int hold_left     = 0;
   int stall_left    = 0;

   error_tolerant_bit_pattern_detector_core #(
      .REG_BITS (etbpd_pkg::MAX_BITS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   // result side: long holds on request, random stall bursts otherwise
   initial begin
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (rsp_stalls_on && $urandom_range(0, 6) == 0) begin
            rsp_tready <= 1'b0;
            stall_left = $urandom_range(0, 13);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // check every accepted result
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_correlation(rsp_tdata);
   end

   function automatic bit [etbpd_pkg::MAX_BITS-1:0] random_wide();
      return {$urandom, $urandom, $urandom, $urandom};
   endfunction

   // offer one bit, optionally after an idle burst, and wait for acceptance
   task automatic send_bit(input bit b);
      if (req_gaps_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'b0, b};
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      sb.predict_correlation(b);
      bits_sent++;
   endtask

   task automatic send_noise(input int n);
      repeat (n) send_bit(1'($urandom_range(0, 1)));
   endtask

   // send a word oldest bit first so it lines up with the pattern, with some bits flipped
   task automatic send_word(input bit [etbpd_pkg::MAX_BITS-1:0] word, input int len,
                            input int flips);
      bit [etbpd_pkg::MAX_BITS-1:0] flip_mask;
      flip_mask = '0;
      repeat (flips) flip_mask[$urandom_range(len - 1, 0)] = 1'b1;
      for (int i = len - 1; i >= 0; i--)
         send_bit(word[i] ^ flip_mask[i]);
   endtask

   // stop offering and wait for every outstanding result
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic csr_put(input logic [etbpd_pkg::CSR_IDX_W-1:0] index,
                          input logic [etbpd_pkg::CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      sb.write_reg(index, data);
   endtask

   // write all registers, then one stray write past the register map
   task automatic load_settings(input bit [etbpd_pkg::MAX_BITS-1:0] pat,
                                input bit [etbpd_pkg::MAX_BITS-1:0] msk,
                                input bit [etbpd_pkg::CSR_DATA_W-1:0] max_word);
      csr_put(etbpd_pkg::REG_PAT_RECENT, pat[etbpd_pkg::HALF_W-1:0]);
      csr_put(etbpd_pkg::REG_PAT_OLDER,  pat[etbpd_pkg::MAX_BITS-1:etbpd_pkg::HALF_W]);
      csr_put(etbpd_pkg::REG_MSK_RECENT, msk[etbpd_pkg::HALF_W-1:0]);
      csr_put(etbpd_pkg::REG_MSK_OLDER,  msk[etbpd_pkg::MAX_BITS-1:etbpd_pkg::HALF_W]);
      csr_put(etbpd_pkg::REG_MAX_ERR,    max_word);
      csr_put(etbpd_pkg::CSR_IDX_W'($urandom_range(etbpd_tb_pkg::REG_SPARE_HI,
                                                   etbpd_tb_pkg::REG_SPARE_LO)),
              {$urandom, $urandom});
      csr_we <= 1'b0;
   endtask

   // stimulus
   initial begin
      bit [etbpd_pkg::MAX_BITS-1:0]   pat;
      bit [etbpd_pkg::MAX_BITS-1:0]   msk;
      bit [etbpd_pkg::CSR_DATA_W-1:0] max_word;
      int                             len;
      int                             phase;
      int                             phase_end;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // registers at reset: empty mask, every bit matches
      send_bit(1'b0);
      send_bit(1'b1);
      send_bit(1'b1);

      // history from the earlier bits against an all-ones pattern, all positions compared
      drain_results();
      load_settings('1, '1, 64'd0);
      send_bit(1'b0);
      send_bit(1'b0);
      send_bit(1'b1);
      send_bit(1'b1);

      // largest threshold always matches
      drain_results();
      load_settings('0, '1, 64'hff);
      send_bit(1'b1);
      send_bit(1'b0);
      send_bit(1'b1);

      // threshold of 128 carried in a wide write, older half only
      drain_results();
      load_settings(random_wide(), {{etbpd_pkg::HALF_W{1'b1}}, {etbpd_pkg::HALF_W{1'b0}}},
                    64'hffff_ffff_ffff_ff80);
      send_noise(3);

      // newest and oldest positions alone
      drain_results();
      load_settings({1'b1, {(etbpd_pkg::MAX_BITS-1){1'b0}}},
                    {1'b1, {(etbpd_pkg::MAX_BITS-2){1'b0}}, 1'b1}, 64'd0);
      send_noise(4);

      // empty mask with a zero threshold
      drain_results();
      load_settings(random_wide(), '0, 64'd0);
      send_noise(2);

      // random phases: sync words with a few bit errors inside noise
      phase = 0;
      while (bits_sent < ITEM_TARGET) begin
         drain_results();
         if (bits_sent > ITEM_TARGET * 4 / 5) begin
            req_gaps_on   = 1'b0;
            rsp_stalls_on = 1'b0;
         end

         case ($urandom_range(0, 5))
            0:       pat = '0;
            1:       pat = '1;
            default: pat = random_wide();
         endcase

         case ($urandom_range(0, 4))
            0:       len = etbpd_pkg::MAX_BITS;
            1:       len = $urandom_range(1, etbpd_pkg::HALF_W);
            2:       len = $urandom_range(etbpd_pkg::HALF_W + 1, etbpd_pkg::MAX_BITS);
            3:       len = $urandom_range(1, etbpd_pkg::MAX_BITS);
            default: len = $urandom_range(8, 40);
         endcase
         msk = {etbpd_pkg::MAX_BITS{1'b1}} >> (etbpd_pkg::MAX_BITS - len);
         if ($urandom_range(0, 3) == 0)
            msk &= random_wide();
         if ($urandom_range(0, 9) == 0)
            msk = '0;

         max_word = {$urandom, $urandom};
         case ($urandom_range(0, 5))
            0:       max_word = '0;
            1:       max_word[7:0] = 8'd128;
            2:       max_word[7:0] = 8'hff;
            3:       ;
            default: max_word = etbpd_pkg::CSR_DATA_W'($urandom_range(0, 6));
         endcase
         load_settings(pat, msk, max_word);

         // long result hold while bits keep coming: the pipeline fills and backs up
         if (phase == 3) begin
            req_gaps_on = 1'b0;
            hold_left   = LONG_HOLD;
         end

         phase_end = bits_sent + PHASE_ITEMS;
         while (bits_sent < phase_end) begin
            send_noise($urandom_range(0, 12));
            if ($urandom_range(0, 4) == 0)
               send_word(pat, len, $urandom_range(0, len / 2));
            else
               send_word(pat, len, $urandom_range(0, 5));
         end

         req_gaps_on = rsp_stalls_on;
         phase++;
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0)
         $display("error_tolerant_bit_pattern_detector_core: match");
      else
         $display("error_tolerant_bit_pattern_detector_core: mismatch");
      $finish;
   end

   // run time limit
   initial begin
      #3_200_000;
      $display("error_tolerant_bit_pattern_detector_core: mismatch");
      $finish;
   end

endmodule

FILE: error_tolerant_bit_pattern_detector_core.f
hdl/etbpd_pkg.sv
hdl/etbpd_cell.sv
hdl/etbpd_sum.sv
hdl/error_tolerant_bit_pattern_detector_core.sv
tb/etbpd_tb_pkg.sv
tb/error_tolerant_bit_pattern_detector_core_tb.sv
